>>> src/imr_pkg.sv
`default_nettype none
package imr_pkg;

	localparam int MAX_SIDE     = 512;
	localparam int MAX_BATCH    = 16;
	localparam int MAX_CHANNELS = 16;
	localparam int MAX_LABELS   = 256;
	localparam int DIV_W        = 10;
	localparam int FRONT_STAGES = DIV_W;
	localparam int BACK_STAGES  = 12;
	localparam int QDEPTH       = 16;

	typedef enum logic [2:0] {
		REG_WINDOW_HEIGHT = 3'd0,
		REG_WINDOW_WIDTH  = 3'd1,
		REG_IMAGE_HEIGHT  = 3'd2,
		REG_IMAGE_WIDTH   = 3'd3,
		REG_BATCH_COUNT   = 3'd4,
		REG_CHANNEL_COUNT = 3'd5,
		REG_REVERSE_ORDER = 3'd6,
		REG_LABEL_COUNT   = 3'd7
	} reg_idx_t;

	// clamped configuration as the datapath uses it
	typedef struct packed {
		logic [9:0] wh;
		logic [9:0] ww;
		logic [9:0] ih;
		logic [9:0] iw;
		logic [4:0] nb;
		logic [4:0] nc;
		logic       rev;
		logic [8:0] nl;
	} cfg_t;

	typedef struct packed {
		logic [DIV_W-1:0] r;
		logic [DIV_W-1:0] n;
	} div_t;

	typedef struct packed {
		logic              empty;
		logic [4:0]        count;
	} qstat_t;

	// one classified word, as it sits in the queue
	typedef struct packed {
		logic [3:0]         img;
		logic [3:0]         ch;
		logic [31:0]        pix;
		logic [7:0]         label;
		logic signed [15:0] top;
		logic signed [15:0] left;
		logic signed [15:0] bot;
		logic signed [15:0] right;
		logic [15:0]        oh;
		logic [15:0]        ow;
		logic [8:0]         wx;
		logic [8:0]         wy;
		logic [8:0]         inx;
		logic [8:0]         iny;
		logic [9:0]         across;
		logic               in_win;
		logic               lerr;
	} q_t;

	// one restoring division step: shift in the next dividend bit
	function automatic div_t div_step(div_t s, logic [DIV_W-1:0] d);
		logic [DIV_W:0] sh;
		logic [DIV_W:0] diff;
		logic           ge;
		div_t           o;
		sh   = {s.r, s.n[DIV_W-1]};
		diff = sh - {1'b0, d};
		ge   = (sh >= {1'b0, d});
		o.n  = {s.n[DIV_W-2:0], ge};
		o.r  = ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
		return o;
	endfunction

endpackage
`default_nettype wire

>>> src/imr_in_if.sv
`default_nettype none
interface imr_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  image_number;
	logic [3:0]  channel_number;
	logic [8:0]  row;
	logic [8:0]  column;
	logic [31:0] pixel_value;
	logic [7:0]  object_label;
	logic signed [15:0] object_top;
	logic signed [15:0] object_left;
	logic signed [15:0] object_bottom;
	logic signed [15:0] object_right;
	logic [15:0] orig_height;
	logic [15:0] orig_width;

	modport source(output valid, image_number, channel_number, row, column, pixel_value,
		object_label, object_top, object_left, object_bottom, object_right,
		orig_height, orig_width, input ready);
	modport sink(input valid, image_number, channel_number, row, column, pixel_value,
		object_label, object_top, object_left, object_bottom, object_right,
		orig_height, orig_width, output ready);
endinterface
`default_nettype wire

>>> src/imr_out_if.sv
`default_nettype none
interface imr_out_if;
	logic        valid;
	logic        ready;
	logic [25:0] dest_index;
	logic [31:0] pixel_out;
	logic [21:0] window_index;
	logic [29:0] label_slot;
	logic [16:0] overlap_ratio;
	logic        clip_horizontal;
	logic        clip_vertical;
	logic        in_window;
	logic        label_error;

	modport source(output valid, dest_index, pixel_out, window_index, label_slot,
		overlap_ratio, clip_horizontal, clip_vertical, in_window, label_error, input ready);
	modport sink(input valid, dest_index, pixel_out, window_index, label_slot,
		overlap_ratio, clip_horizontal, clip_vertical, in_window, label_error, output ready);
endinterface
`default_nettype wire

>>> src/imr_front.sv
`default_nettype none
module imr_front (
	input  logic            clk,
	input  logic            arst_n,
	imr_in_if.sink          pixel,
	input  imr_pkg::cfg_t   cfg,
	input  imr_pkg::qstat_t qstat,
	output logic            push,
	output imr_pkg::q_t     entry
);

	typedef struct packed {
		logic [3:0]         img;
		logic [3:0]         ch;
		logic [31:0]        pix;
		logic [7:0]         label;
		logic signed [15:0] top;
		logic signed [15:0] left;
		logic signed [15:0] bot;
		logic signed [15:0] right;
		logic [15:0]        oh;
		logic [15:0]        ow;
		imr_pkg::div_t      dc;
		imr_pkg::div_t      dr;
		imr_pkg::div_t      dw;
		imr_pkg::div_t      dh;
	} fr_t;

	fr_t                              init;
	fr_t                              nxt    [1:imr_pkg::FRONT_STAGES];
	fr_t                              pipe_q [1:imr_pkg::FRONT_STAGES];
	logic [imr_pkg::FRONT_STAGES:1]   v_q;
	logic [4:0]                       infl_q;
	logic                             acc;
	fr_t                              last;
	logic [9:0]                       wx_raw;
	logic [9:0]                       wy_raw;
	logic [9:0]                       wx_rev;
	logic [9:0]                       wy_rev;

	function automatic fr_t fr_step(fr_t s, imr_pkg::cfg_t c);
		fr_t o;
		o    = s;
		o.dc = imr_pkg::div_step(s.dc, c.ww);
		o.dr = imr_pkg::div_step(s.dr, c.wh);
		o.dw = imr_pkg::div_step(s.dw, c.ww);
		o.dh = imr_pkg::div_step(s.dh, c.wh);
		return o;
	endfunction

	// credits: words in flight plus words queued never exceed the queue depth
	assign pixel.ready = ({1'b0, infl_q} + {1'b0, qstat.count}) < 6'(imr_pkg::QDEPTH);
	assign acc         = pixel.valid && pixel.ready;

	always_comb begin
		init       = '0;
		init.img   = pixel.image_number;
		init.ch    = pixel.channel_number;
		init.pix   = pixel.pixel_value;
		init.label = pixel.object_label;
		init.top   = pixel.object_top;
		init.left  = pixel.object_left;
		init.bot   = pixel.object_bottom;
		init.right = pixel.object_right;
		init.oh    = pixel.orig_height;
		init.ow    = pixel.orig_width;
		init.dc.n  = {1'b0, pixel.column};
		init.dr.n  = {1'b0, pixel.row};
		init.dw.n  = cfg.iw;
		init.dh.n  = cfg.ih;
	end

	for (genvar k = 1; k <= imr_pkg::FRONT_STAGES; k++) begin : g_st
		if (k == 1) begin : g_first
			assign nxt[k] = fr_step(init, cfg);
		end else begin : g_next
			assign nxt[k] = fr_step(pipe_q[k-1], cfg);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= imr_pkg::FRONT_STAGES; k++) pipe_q[k] <= nxt[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			infl_q <= '0;
		end else begin
			v_q    <= {v_q[imr_pkg::FRONT_STAGES-1:1], acc};
			infl_q <= infl_q + {4'd0, acc} - {4'd0, v_q[imr_pkg::FRONT_STAGES]};
		end
	end

	// classify: window position, offset in window, whole-window test, label check
	assign last   = pipe_q[imr_pkg::FRONT_STAGES];
	assign wx_raw = last.dc.n;
	assign wy_raw = last.dr.n;
	assign wx_rev = last.dw.n - wx_raw - 10'd1;
	assign wy_rev = last.dh.n - wy_raw - 10'd1;
	assign push   = v_q[imr_pkg::FRONT_STAGES];

	always_comb begin
		entry        = '0;
		entry.img    = last.img;
		entry.ch     = last.ch;
		entry.pix    = last.pix;
		entry.label  = last.label;
		entry.top    = last.top;
		entry.left   = last.left;
		entry.bot    = last.bot;
		entry.right  = last.right;
		entry.oh     = last.oh;
		entry.ow     = last.ow;
		entry.wx     = cfg.rev ? wx_rev[8:0] : wx_raw[8:0];
		entry.wy     = cfg.rev ? wy_rev[8:0] : wy_raw[8:0];
		entry.inx    = last.dc.r[8:0];
		entry.iny    = last.dr.r[8:0];
		entry.across = last.dw.n;
		entry.in_win = (wx_raw < last.dw.n) && (wy_raw < last.dh.n)
			&& ({1'b0, last.img} < cfg.nb) && ({1'b0, last.ch} < cfg.nc);
		entry.lerr   = {1'b0, last.label} >= cfg.nl;
	end

endmodule
`default_nettype wire

>>> src/imr_queue.sv
`default_nettype none
module imr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  imr_pkg::q_t     wdata,
	input  logic            pop,
	output imr_pkg::q_t     rdata,
	output imr_pkg::qstat_t qstat
);

	imr_pkg::q_t mem_q [imr_pkg::QDEPTH];
	logic [3:0]  wr_q;
	logic [3:0]  rd_q;
	logic [4:0]  cnt_q;

	assign rdata       = mem_q[rd_q];
	assign qstat.empty = (cnt_q == 5'd0);
	assign qstat.count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 4'd1;
			if (pop)  rd_q <= rd_q + 4'd1;
			cnt_q <= cnt_q + {4'd0, push} - {4'd0, pop};
		end
	end

endmodule
`default_nettype wire

>>> src/imr_back.sv
`default_nettype none
module imr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  imr_pkg::cfg_t   cfg,
	input  imr_pkg::q_t     head,
	input  imr_pkg::qstat_t qstat,
	output logic            pop,
	imr_out_if.source       result
);

	typedef struct packed {
		imr_pkg::q_t e;
		logic [18:0] p;
		logic [9:0]  x0;
		logic [9:0]  y0;
		logic [18:0] pos;
		logic [10:0] x1;
		logic [10:0] y1;
		logic [9:0]  dy;
		logic [9:0]  dx;
		logic        clip_h;
		logic        clip_v;
		logic [22:0] widx;
		logic [19:0] area;
		logic [18:0] wa;
		logic [25:0] t;
		logic [29:0] slot;
		logic [25:0] u;
		logic [25:0] dest;
		logic [18:0] r;
		logic [16:0] q;
	} bk_t;

	bk_t                            init;
	bk_t                            nxt    [1:imr_pkg::BACK_STAGES];
	bk_t                            pipe_q [1:imr_pkg::BACK_STAGES];
	logic [imr_pkg::BACK_STAGES:1]  v_q;
	logic                           en;
	bk_t                            fin;

	// one bit of the overlap quotient: remainder stays below the window area
	function automatic bk_t ratio_step(bk_t s);
		logic [19:0] r2;
		logic [19:0] diff;
		logic        ge;
		bk_t         o;
		o    = s;
		r2   = {s.r, 1'b0};
		diff = r2 - {1'b0, s.wa};
		ge   = (r2 >= {1'b0, s.wa});
		o.r  = ge ? diff[18:0] : r2[18:0];
		o.q  = {s.q[15:0], ge};
		return o;
	endfunction

	function automatic bk_t bk_stage(int k, bk_t s, imr_pkg::cfg_t c);
		bk_t                o;
		logic [18:0]        p19;
		logic [18:0]        x19;
		logic [18:0]        y19;
		logic signed [16:0] x0e, x1e, y0e, y1e, tp, bt, lf, rt;
		logic signed [16:0] ix0, ix1, iy0, iy1, dxs, dys;
		logic               ovl;
		logic               fit;
		logic [23:0]        w24;
		logic [27:0]        t28;
		logic [31:0]        s32;
		logic [35:0]        m36;
		logic [20:0]        ad;
		o = s;
		case (k)
			1: begin
				p19  = s.e.across * s.e.wy;
				x19  = s.e.wx * c.ww;
				y19  = s.e.wy * c.wh;
				o.p  = p19;
				o.x0 = x19[9:0];
				o.y0 = y19[9:0];
			end
			2: begin
				o.pos = s.p + {10'd0, s.e.wx};
				o.x1  = {1'b0, s.x0} + {1'b0, c.ww};
				o.y1  = {1'b0, s.y0} + {1'b0, c.wh};
				x0e   = $signed({7'd0, s.x0});
				y0e   = $signed({7'd0, s.y0});
				x1e   = $signed({6'd0, o.x1});
				y1e   = $signed({6'd0, o.y1});
				tp    = $signed({s.e.top[15], s.e.top});
				bt    = $signed({s.e.bot[15], s.e.bot});
				lf    = $signed({s.e.left[15], s.e.left});
				rt    = $signed({s.e.right[15], s.e.right});
				iy0   = (y0e > tp) ? y0e : tp;
				ix0   = (x0e > lf) ? x0e : lf;
				iy1   = (y1e < bt) ? y1e : bt;
				ix1   = (x1e < rt) ? x1e : rt;
				dys   = iy1 - iy0;
				dxs   = ix1 - ix0;
				ovl   = (iy0 < iy1) && (ix0 < ix1);
				o.dy  = ovl ? dys[9:0] : 10'd0;
				o.dx  = ovl ? dxs[9:0] : 10'd0;
				fit   = ({5'd0, o.x1} <= s.e.ow) && ({5'd0, o.y1} <= s.e.oh);
				o.clip_h = fit && (s.e.wx != 9'd0);
				o.clip_v = fit && (s.e.wy != 9'd0);
			end
			3: begin
				w24    = s.pos * c.nb + {20'd0, s.e.img};
				o.widx = w24[22:0];
				o.area = s.dy * s.dx;
				o.wa   = c.wh * c.ww;
			end
			4: begin
				t28    = s.widx * c.nc + {24'd0, s.e.ch};
				o.t    = t28[25:0];
				s32    = s.widx * c.nl + {24'd0, s.e.label};
				o.slot = s32[29:0];
				ad     = {1'b0, s.area} - {2'd0, s.wa};
				o.q    = {16'd0, ~ad[20]};
				o.r    = ad[20] ? s.area[18:0] : ad[18:0];
			end
			5: begin
				m36 = s.t * c.wh + {27'd0, s.e.iny};
				o   = ratio_step(ratio_step(s));
				o.u = m36[25:0];
			end
			6: begin
				m36    = s.u * c.ww + {27'd0, s.e.inx};
				o      = ratio_step(ratio_step(s));
				o.dest = m36[25:0];
			end
			default: begin
				o = ratio_step(ratio_step(s));
			end
		endcase
		return o;
	endfunction

	assign en  = !v_q[imr_pkg::BACK_STAGES] || result.ready;
	assign pop = en && !qstat.empty;

	always_comb begin
		init   = '0;
		init.e = head;
	end

	for (genvar k = 1; k <= imr_pkg::BACK_STAGES; k++) begin : g_st
		if (k == 1) begin : g_first
			assign nxt[k] = bk_stage(k, init, cfg);
		end else begin : g_next
			assign nxt[k] = bk_stage(k, pipe_q[k-1], cfg);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= imr_pkg::BACK_STAGES; k++) pipe_q[k] <= nxt[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[imr_pkg::BACK_STAGES-1:1], !qstat.empty};
		end
	end

	// outside a whole window only the pixel word, the in-window flag and label check go out
	assign fin                    = pipe_q[imr_pkg::BACK_STAGES];
	assign result.valid           = v_q[imr_pkg::BACK_STAGES];
	assign result.dest_index      = fin.e.in_win ? fin.dest : 26'd0;
	assign result.pixel_out       = fin.e.pix;
	assign result.window_index    = fin.e.in_win ? fin.widx[21:0] : 22'd0;
	assign result.label_slot      = fin.e.in_win ? fin.slot : 30'd0;
	assign result.overlap_ratio   = fin.e.in_win ? fin.q : 17'd0;
	assign result.clip_horizontal = fin.e.in_win && fin.clip_h;
	assign result.clip_vertical   = fin.e.in_win && fin.clip_v;
	assign result.in_window       = fin.e.in_win;
	assign result.label_error     = fin.e.lerr;

endmodule
`default_nettype wire

>>> src/image_to_window_remap.sv
// Pixel-to-window remapper.
// Pixels enter on the "pixel" channel (valid/ready), one word per pixel with its
// coordinates, object box, label and original image size. Each pixel gives one
// word on the "result" channel, in arrival order: its NCHW index in the window
// tensor, window number, label slot, box-over-window overlap ratio and clip flags.
// Configuration goes through cfg_we/cfg_index/cfg_data; writing it only while
// the block is idle is left to the user. Throughput: one pixel per cycle while
// the receiver keeps up. A pixel passes the front divider pipeline (one quotient
// bit per cycle for column, row and window counts), the queue and the back
// pipeline (index multiplies and a two-bit-per-cycle overlap divider). If the
// receiver stalls, the back pipeline holds, the 16-word queue fills from the
// front, and pixel.ready drops once the words in flight plus those queued reach
// 16. Reset clears valid bits, counters and queue pointers, loads the register
// defaults; that no pixel is taken while reset is asserted is up to the source.
`default_nettype none
module image_to_window_remap (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	imr_in_if.sink      pixel,
	imr_out_if.source   result
);

	logic [9:0]      wh_q;
	logic [9:0]      ww_q;
	logic [9:0]      ih_q;
	logic [9:0]      iw_q;
	logic [4:0]      nb_q;
	logic [4:0]      nc_q;
	logic            rev_q;
	logic [8:0]      nl_q;
	imr_pkg::cfg_t   cfg;
	imr_pkg::qstat_t qstat;
	imr_pkg::q_t     entry;
	imr_pkg::q_t     head;
	logic            push;
	logic            pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wh_q  <= 10'd1;
			ww_q  <= 10'd1;
			ih_q  <= 10'(imr_pkg::MAX_SIDE);
			iw_q  <= 10'(imr_pkg::MAX_SIDE);
			nb_q  <= 5'd1;
			nc_q  <= 5'd1;
			rev_q <= 1'b0;
			nl_q  <= 9'd1;
		end else if (cfg_we) begin
			unique case (imr_pkg::reg_idx_t'(cfg_index))
				imr_pkg::REG_WINDOW_HEIGHT: wh_q  <= cfg_data;
				imr_pkg::REG_WINDOW_WIDTH:  ww_q  <= cfg_data;
				imr_pkg::REG_IMAGE_HEIGHT:  ih_q  <= cfg_data;
				imr_pkg::REG_IMAGE_WIDTH:   iw_q  <= cfg_data;
				imr_pkg::REG_BATCH_COUNT:   nb_q  <= cfg_data[4:0];
				imr_pkg::REG_CHANNEL_COUNT: nc_q  <= cfg_data[4:0];
				imr_pkg::REG_REVERSE_ORDER: rev_q <= cfg_data[0];
				imr_pkg::REG_LABEL_COUNT:   nl_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// registers are used clamped to their legal ranges
	always_comb begin
		cfg.wh  = (wh_q == 10'd0) ? 10'd1 :
			(wh_q > 10'(imr_pkg::MAX_SIDE)) ? 10'(imr_pkg::MAX_SIDE) : wh_q;
		cfg.ww  = (ww_q == 10'd0) ? 10'd1 :
			(ww_q > 10'(imr_pkg::MAX_SIDE)) ? 10'(imr_pkg::MAX_SIDE) : ww_q;
		cfg.ih  = (ih_q == 10'd0) ? 10'd1 :
			(ih_q > 10'(imr_pkg::MAX_SIDE)) ? 10'(imr_pkg::MAX_SIDE) : ih_q;
		cfg.iw  = (iw_q == 10'd0) ? 10'd1 :
			(iw_q > 10'(imr_pkg::MAX_SIDE)) ? 10'(imr_pkg::MAX_SIDE) : iw_q;
		cfg.nb  = (nb_q == 5'd0) ? 5'd1 :
			(nb_q > 5'(imr_pkg::MAX_BATCH)) ? 5'(imr_pkg::MAX_BATCH) : nb_q;
		cfg.nc  = (nc_q == 5'd0) ? 5'd1 :
			(nc_q > 5'(imr_pkg::MAX_CHANNELS)) ? 5'(imr_pkg::MAX_CHANNELS) : nc_q;
		cfg.rev = rev_q;
		cfg.nl  = (nl_q == 9'd0) ? 9'd1 :
			(nl_q > 9'(imr_pkg::MAX_LABELS)) ? 9'(imr_pkg::MAX_LABELS) : nl_q;
	end

	imr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.cfg    (cfg),
		.qstat  (qstat),
		.push   (push),
		.entry  (entry)
	);

	imr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.rdata  (head),
		.qstat  (qstat)
	);

	imr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

endmodule
`default_nettype wire

>>> src/imr_checker.sv
`default_nettype none
module imr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [25:0] dest_index,
	input logic [31:0] pixel_out,
	input logic [21:0] window_index,
	input logic [29:0] label_slot,
	input logic [16:0] overlap_ratio,
	input logic        clip_horizontal,
	input logic        clip_vertical,
	input logic        in_window
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out))
		else $error("result word dropped or changed while stalled");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_window |-> dest_index == 26'd0 && window_index == 22'd0
			&& label_slot == 30'd0 && overlap_ratio == 17'd0
			&& !clip_horizontal && !clip_vertical)
		else $error("word outside any window carries window data");

	a_ratio_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> overlap_ratio <= 17'd65536)
		else $error("overlap ratio above one");

	a_first_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_window && window_index == 22'd0 |-> !clip_horizontal && !clip_vertical)
		else $error("clip flag set on the corner window");

endmodule

bind image_to_window_remap imr_checker u_imr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.dest_index      (result.dest_index),
	.pixel_out       (result.pixel_out),
	.window_index    (result.window_index),
	.label_slot      (result.label_slot),
	.overlap_ratio   (result.overlap_ratio),
	.clip_horizontal (result.clip_horizontal),
	.clip_vertical   (result.clip_vertical),
	.in_window       (result.in_window)
);
`default_nettype wire

>>> tb/imr_tb_if.sv
`timescale 1ns / 100ps
// the channel interfaces come with the RTL; nothing extra is needed here
package imr_tb_pkg;
	typedef struct packed {
		logic [3:0]  img;
		logic [3:0]  ch;
		logic [8:0]  row;
		logic [8:0]  col;
		logic [31:0] pix;
		logic [7:0]  label;
		logic [15:0] top;
		logic [15:0] left;
		logic [15:0] bot;
		logic [15:0] right;
		logic [15:0] oh;
		logic [15:0] ow;
	} pixel_word_t;

	typedef struct packed {
		logic [25:0] dest;
		logic [31:0] pix;
		logic [21:0] widx;
		logic [29:0] slot;
		logic [16:0] ratio;
		logic        clip_h;
		logic        clip_v;
		logic        in_win;
		logic        lerr;
	} remap_word_t;
endpackage

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import imr_pkg::*;
	import imr_tb_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [9:0] cfg_data;

	imr_in_if  pixel ();
	imr_out_if result ();

	image_to_window_remap dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pixel(pixel.sink), .result(result.source)
	);

	pixel_word_t pending_pixels[$];
	remap_word_t expected_words[$];
	logic [9:0]  cfg_shadow[8];
	int          send_idle_pct, recv_stall_pct, hold_cycles;
	int          mismatches, quiet_cycles;
	bit          failed;
	bit          in_taken;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned clampv(longint unsigned v, longint unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic remap_word_t remap_pixel(pixel_word_t p);
		longint unsigned wh, ww, ih, iw, nb, nc, nl, across, down;
		longint unsigned wx, wy, area;
		longint signed   x0, x1, y0, y1, ix0, ix1, iy0, iy1;
		bit              rev;
		remap_word_t     r;
		wh = clampv(cfg_shadow[REG_WINDOW_HEIGHT], MAX_SIDE);
		ww = clampv(cfg_shadow[REG_WINDOW_WIDTH], MAX_SIDE);
		ih = clampv(cfg_shadow[REG_IMAGE_HEIGHT], MAX_SIDE);
		iw = clampv(cfg_shadow[REG_IMAGE_WIDTH], MAX_SIDE);
		nb = clampv(cfg_shadow[REG_BATCH_COUNT] & 10'h1f, MAX_BATCH);
		nc = clampv(cfg_shadow[REG_CHANNEL_COUNT] & 10'h1f, MAX_CHANNELS);
		rev = cfg_shadow[REG_REVERSE_ORDER][0];
		nl = clampv(cfg_shadow[REG_LABEL_COUNT] & 10'h1ff, MAX_LABELS);
		r = '0;
		r.pix = p.pix;
		r.lerr = p.label >= nl;
		across = iw / ww;
		down = ih / wh;
		r.in_win = p.row < down * wh && p.col < across * ww && p.img < nb && p.ch < nc;
		if (r.in_win) begin
			wx = p.col / ww;
			wy = p.row / wh;
			if (rev) begin
				wx = across - wx - 1;
				wy = down - wy - 1;
			end
			r.widx = nb * (across * wy + wx) + p.img;
			r.dest = ((r.widx * nc + p.ch) * wh + p.row % wh) * ww + p.col % ww;
			r.slot = r.widx * nl + p.label;
			x0 = wx * ww;
			x1 = x0 + ww;
			y0 = wy * wh;
			y1 = y0 + wh;
			iy0 = (y0 > $signed(p.top)) ? y0 : $signed(p.top);
			ix0 = (x0 > $signed(p.left)) ? x0 : $signed(p.left);
			iy1 = (y1 < $signed(p.bot)) ? y1 : $signed(p.bot);
			ix1 = (x1 < $signed(p.right)) ? x1 : $signed(p.right);
			if (iy0 < iy1 && ix0 < ix1) begin
				area = (iy1 - iy0) * (ix1 - ix0);
				area = (area << 16) / (wh * ww);
				r.ratio = (area > 17'h1ffff) ? 17'h1ffff : area;
			end
			if (x1 <= p.ow && y1 <= p.oh) begin
				r.clip_h = wx != 0;
				r.clip_v = wy != 0;
			end
		end
		return r;
	endfunction

	// driver: a word stays on the channel until it is taken
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel.valid <= 0;
		end else if (!pixel.valid || in_taken) begin
			if (pending_pixels.size() > 0 && ($urandom_range(99) >= send_idle_pct)) begin
				pixel.valid <= 1;
				{pixel.image_number, pixel.channel_number, pixel.row, pixel.column,
					pixel.pixel_value, pixel.object_label, pixel.object_top,
					pixel.object_left, pixel.object_bottom, pixel.object_right,
					pixel.orig_height, pixel.orig_width} <= pending_pixels[0];
			end else begin
				pixel.valid <= 0;
			end
		end
	end

	// receiver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result.ready <= 0;
		end else begin
			result.ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// monitor
	always @(posedge clk) begin
		remap_word_t got, want;
		in_taken <= arst_n && pixel.valid && pixel.ready;
		if (arst_n) begin
			if ((pixel.valid && pixel.ready) || (result.valid && result.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (result.valid && result.ready) begin
				got = {result.dest_index, result.pixel_out, result.window_index,
					result.label_slot, result.overlap_ratio, result.clip_horizontal,
					result.clip_vertical, result.in_window, result.label_error};
				if (expected_words.size() == 0) begin
					failed = 1;
					if (mismatches < 10) $display("unexpected word %h", got);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						failed = 1;
						if (mismatches < 10)
							$display("mismatch: expected %h actual %h", want, got);
						mismatches++;
					end
				end
			end
			if (pixel.valid && pixel.ready)
				expected_words.insert(expected_words.size(),
					remap_pixel(pending_pixels.pop_front()));
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles > 5000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(600);
			default: return $urandom_range(520) - 8;
		endcase
	endfunction

	function automatic pixel_word_t rand_pixel();
		pixel_word_t p;
		p = '0;
		p.img = $urandom;
		p.ch = $urandom;
		p.row = $urandom;
		p.col = $urandom;
		p.pix = $urandom;
		p.label = $urandom;
		p.top = rand_coord();
		p.left = rand_coord();
		p.bot = rand_coord();
		p.right = rand_coord();
		p.oh = $urandom_range(1) ? $urandom : $urandom_range(520);
		p.ow = $urandom_range(1) ? $urandom : $urandom_range(520);
		// mostly keep coordinates inside the configured batch and image
		if ($urandom_range(9) < 8) begin
			p.img = $urandom_range(clampv(cfg_shadow[REG_BATCH_COUNT], 16) - 1);
			p.ch = $urandom_range(clampv(cfg_shadow[REG_CHANNEL_COUNT], 16) - 1);
			p.row = $urandom_range(clampv(cfg_shadow[REG_IMAGE_HEIGHT], 512) - 1);
			p.col = $urandom_range(clampv(cfg_shadow[REG_IMAGE_WIDTH], 512) - 1);
			p.label = $urandom_range(clampv(cfg_shadow[REG_LABEL_COUNT], 256));
		end
		return p;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [9:0] v);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = v;
		cfg_shadow[idx] = v;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic drain();
		while (pending_pixels.size() > 0 || expected_words.size() > 0 || pixel.valid)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic random_settings();
		write_reg(REG_WINDOW_HEIGHT, $urandom_range(1) ? $urandom_range(1, 64) : $urandom);
		write_reg(REG_WINDOW_WIDTH, $urandom_range(1) ? $urandom_range(1, 64) : $urandom);
		write_reg(REG_IMAGE_HEIGHT, $urandom_range(1) ? $urandom_range(1, 512) : $urandom);
		write_reg(REG_IMAGE_WIDTH, $urandom_range(1) ? $urandom_range(1, 512) : $urandom);
		write_reg(REG_BATCH_COUNT, $urandom_range(31));
		write_reg(REG_CHANNEL_COUNT, $urandom_range(31));
		write_reg(REG_REVERSE_ORDER, $urandom_range(1));
		write_reg(REG_LABEL_COUNT, $urandom_range(511));
	endtask

	initial begin
		pixel_word_t p;
		int          ph;
		cfg_we = 0;
		cfg_index = REG_WINDOW_HEIGHT;
		cfg_data = 0;
		result.ready = 0;
		pixel.valid = 0;
		{pixel.image_number, pixel.channel_number, pixel.row, pixel.column,
			pixel.pixel_value, pixel.object_label, pixel.object_top,
			pixel.object_left, pixel.object_bottom, pixel.object_right,
			pixel.orig_height, pixel.orig_width} = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		mismatches = 0;
		quiet_cycles = 0;
		failed = 0;
		in_taken = 0;
		cfg_shadow = '{10'd1, 10'd1, 10'd512, 10'd512, 10'd1, 10'd1, 10'd0, 10'd1};
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset settings: every pixel is its own window
		p = '0;
		pending_pixels.insert(pending_pixels.size(), p);
		p = '1;
		pending_pixels.insert(pending_pixels.size(), p);
		drain();
		// extremes: largest windows, out-of-range clamping, largest label count
		write_reg(REG_WINDOW_HEIGHT, 10'd512);
		write_reg(REG_WINDOW_WIDTH, 10'd1023);
		write_reg(REG_IMAGE_HEIGHT, 10'd0);
		write_reg(REG_IMAGE_WIDTH, 10'd1023);
		write_reg(REG_BATCH_COUNT, 10'd31);
		write_reg(REG_CHANNEL_COUNT, 10'd0);
		write_reg(REG_REVERSE_ORDER, 10'd1);
		write_reg(REG_LABEL_COUNT, 10'd511);
		for (int i = 0; i < 6; i++) pending_pixels.insert(pending_pixels.size(), rand_pixel());
		drain();
		write_reg(REG_WINDOW_HEIGHT, 10'd16);
		write_reg(REG_WINDOW_WIDTH, 10'd32);
		write_reg(REG_IMAGE_HEIGHT, 10'd512);
		write_reg(REG_IMAGE_WIDTH, 10'd500);
		write_reg(REG_BATCH_COUNT, 10'd16);
		write_reg(REG_CHANNEL_COUNT, 10'd16);
		write_reg(REG_LABEL_COUNT, 10'd256);
		// box covering the whole window, beyond last window with top label, box outside
		p = '0; p.row = 5; p.col = 40; p.bot = 16'h7fff; p.right = 16'h7fff;
		p.top = 16'h8000; p.left = 16'h8000; p.oh = 16'hffff; p.ow = 16'hffff;
		pending_pixels.insert(pending_pixels.size(), p);
		p.col = 490; p.label = 8'hff;
		pending_pixels.insert(pending_pixels.size(), p);
		p.col = 200; p.row = 511; p.top = 600; p.img = 15; p.ch = 15;
		pending_pixels.insert(pending_pixels.size(), p);
		for (int i = 0; i < 12; i++) pending_pixels.insert(pending_pixels.size(), rand_pixel());
		drain();

		// pressure: receiver holds off while the sender keeps offering
		hold_cycles = 200;
		for (int i = 0; i < 60; i++) pending_pixels.insert(pending_pixels.size(), rand_pixel());
		drain();

		for (ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			random_settings();
			for (int i = 0; i < 125; i++)
				pending_pixels.insert(pending_pixels.size(), rand_pixel());
			drain();
		end

		if (!failed && expected_words.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

>>> sim.f
src/imr_pkg.sv
src/imr_in_if.sv
src/imr_out_if.sv
src/imr_front.sv
src/imr_queue.sv
src/imr_back.sv
src/image_to_window_remap.sv
src/imr_checker.sv
tb/imr_tb_if.sv
tb/testbench.sv
